[rtl/fpba_pkg.sv]
`timescale 1ns / 1ps
package fpba_pkg;

	// Placement rule codes
	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	// Item command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	// Configuration register indexes
	localparam logic REG_FIT_MODE    = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	localparam int MODE_W  = 2;
	localparam int COUNT_W = 5;
	localparam int INDEX_W = 4;
	localparam int VALUE_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FINISH
	} fpba_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_wr;
		logic clear;
		logic issue;
		logic finish;
	} fpba_ctrl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic limit_zero;
		logic last_issue;
	} fpba_stat_t;

endpackage

[rtl/fit_policy_block_allocator_unit.sv]
// Sequence: a load is written at its accept edge and gives no result; an allocate clears
//   the pick, scans the searched blocks (limit) through the registered table read, waits
//   for the last entry, then finishes and registers its result strobe; at limit 0 it goes
//   straight to finish. Busy holds until finish, so no new item is taken before the result.
// Reset: arst_n clears the controller, the strobe and the mode/count registers;
//   the size table is not cleared. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module fit_policy_block_allocator_unit #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_index,
	input  logic [fpba_pkg::COUNT_W-1:0]      cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic                              command,
	input  logic [fpba_pkg::INDEX_W-1:0]      block_index,
	input  logic [fpba_pkg::VALUE_W-1:0]      size_value,
	output logic                              done,
	output logic                              granted,
	output logic [fpba_pkg::INDEX_W-1:0]      chosen_block
);
	import fpba_pkg::*;

	fpba_ctrl_t ctrl;
	fpba_stat_t stat;

	fpba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	fpba_dpath #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.block_index (block_index),
		.size_value  (size_value),
		.ctrl        (ctrl),
		.stat        (stat),
		.done        (done),
		.granted     (granted),
		.chosen_block(chosen_block)
	);

`ifndef SYNTHESIS
	// An accepted allocate keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_ALLOC) |=> busy)
		else $error("allocate accepted without going busy");

	// A result is a single-cycle strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A refused request reports block zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |-> (chosen_block == '0))
		else $error("refused request with nonzero block");

	// A result only follows the end of a search
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctrl.finish))
		else $error("result without a finished search");
`endif

endmodule

[rtl/fpba_ram.sv]
`timescale 1ns / 1ps
module fpba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                             clk,
	input  logic                                             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     waddr,
	input  logic [WIDTH-1:0]                                 wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     raddr,
	output logic [WIDTH-1:0]                                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/fpba_ctrl.sv]
`timescale 1ns / 1ps
module fpba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 command,
	input  fpba_pkg::fpba_stat_t stat,
	output fpba_pkg::fpba_ctrl_t ctrl,
	output logic                 busy
);
	import fpba_pkg::*;

	fpba_state_t state_q, state_nxt;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && command == CMD_ALLOC) begin
					state_nxt = stat.limit_zero ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.last_issue) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT:   state_nxt = ST_FINISH;
			ST_FINISH: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctrl = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy         = 1'b0;
				ctrl.load_wr = start && command == CMD_LOAD;
				ctrl.clear   = start && command == CMD_ALLOC;
			end
			ST_SCAN:   ctrl.issue  = 1'b1;
			ST_WAIT:   ctrl       = '0;
			ST_FINISH: ctrl.finish = 1'b1;
			default:   busy        = 1'b1;
		endcase
	end

endmodule

[rtl/fpba_dpath.sv]
`timescale 1ns / 1ps
module fpba_dpath #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [fpba_pkg::COUNT_W-1:0]        cfg_wdata,
	input  logic [fpba_pkg::INDEX_W-1:0]        block_index,
	input  logic [fpba_pkg::VALUE_W-1:0]        size_value,
	input  fpba_pkg::fpba_ctrl_t                ctrl,
	output fpba_pkg::fpba_stat_t                stat,
	output logic                                done,
	output logic                                granted,
	output logic [fpba_pkg::INDEX_W-1:0]        chosen_block
);
	import fpba_pkg::*;

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int LW = $clog2(NUM_BLOCKS + 1);

	logic [MODE_W-1:0]     mode_q;
	logic [COUNT_W-1:0]    count_q;
	logic [LW-1:0]         limit;
	logic [SIZE_WIDTH-1:0] port_size;
	logic [SIZE_WIDTH-1:0] need_q;
	logic [AW-1:0]         cnt_q;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic                  found_q;
	logic [AW-1:0]         best_idx_q;
	logic [SIZE_WIDTH-1:0] best_val_q;
	logic [SIZE_WIDTH-1:0] rdata;
	logic                  fits;
	logic                  take;
	logic                  load_ok;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [SIZE_WIDTH-1:0] ram_wdata;
	logic                  done_q;
	logic                  granted_q;
	logic [INDEX_W-1:0]    chosen_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FIRST;
			count_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FIT_MODE:    mode_q  <= cfg_wdata[MODE_W-1:0];
				REG_BLOCK_COUNT: count_q <= cfg_wdata;
				default:         mode_q  <= mode_q;
			endcase
		end
	end

	// Saturate the searched count at the table depth
	assign limit = (32'(count_q) > NUM_BLOCKS) ? LW'(NUM_BLOCKS) : LW'(count_q);
	assign stat.limit_zero = (limit == '0);
	assign stat.last_issue = (LW'(cnt_q) + LW'(1) == limit);

	// Keep only the low size bits
	assign port_size = SIZE_WIDTH'(size_value);
	assign load_ok   = ctrl.load_wr && (32'(block_index) < NUM_BLOCKS);

	// Scan address counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctrl.issue;
			if (ctrl.clear) begin
				cnt_q <= '0;
			end else if (ctrl.issue) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (ctrl.clear) begin
			need_q <= port_size;
		end
	end

	// Decide whether the returning entry replaces the current pick
	assign fits = rd_vld_s1 && (rdata >= need_q);
	always_comb begin
		case (mode_q)
			MODE_BEST:  take = fits && (!found_q || rdata < best_val_q);
			MODE_WORST: take = fits && (!found_q || rdata > best_val_q);
			default:    take = fits && !found_q;
		endcase
	end

	// Track the pick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			best_idx_q <= '0;
			best_val_q <= '0;
		end else if (take) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= rdata;
		end
	end

	// Table write: load, or shrink the picked block
	assign ram_we    = load_ok || (ctrl.finish && found_q);
	assign ram_waddr = ctrl.load_wr ? AW'(block_index) : best_idx_q;
	assign ram_wdata = ctrl.load_wr ? port_size : (best_val_q - need_q);

	fpba_ram #(
		.WIDTH(SIZE_WIDTH),
		.DEPTH(NUM_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q),
		.rdata(rdata)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			granted_q <= found_q;
			chosen_q  <= found_q ? INDEX_W'(best_idx_q) : '0;
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign chosen_block = chosen_q;

endmodule

[verif/fpba_checker.sv]
`timescale 1ns / 1ps
module fpba_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_index,
	input  logic [fpba_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          command,
	input  logic [fpba_pkg::INDEX_W-1:0]  block_index,
	input  logic [fpba_pkg::VALUE_W-1:0]  size_value,
	input  logic                          done,
	input  logic                          granted,
	input  logic [fpba_pkg::INDEX_W-1:0]  chosen_block,
	output int                            fail_count,
	output int                            pending,
	output int                            result_count,
	output int                            grant_count
);
	import fpba_pkg::*;

	localparam int TABLE_DEPTH = 16;

	typedef struct packed {
		logic                 granted;
		logic [INDEX_W-1:0]   block;
	} placement_t;

	placement_t               placement_q[$];
	logic [VALUE_W-1:0]       free_size [TABLE_DEPTH];
	logic [MODE_W-1:0]        mode_reg;
	logic [COUNT_W-1:0]       count_reg;
	int                       fail_tally;
	int                       result_tally;
	int                       grant_tally;

	initial begin
		fail_count = 0;
		pending = 0;
		result_count = 0;
		grant_count = 0;
		fail_tally = 0;
		result_tally = 0;
		grant_tally = 0;
		mode_reg = MODE_FIRST;
		count_reg = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) free_size[i] = '0;
	end

	// Pick a block for a request under the current placement rule
	function automatic placement_t place_request(input logic [VALUE_W-1:0] need);
		placement_t pl;
		int span;
		int pick;
		logic found;
		span = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
		found = 1'b0;
		pick = 0;
		for (int j = 0; j < span; j++) begin
			if (free_size[j] >= need) begin
				if (!found) begin
					found = 1'b1;
					pick = j;
					// first fit, and the spare mode code that behaves like it
					if (mode_reg != MODE_BEST && mode_reg != MODE_WORST) break;
				end else if (mode_reg == MODE_BEST && free_size[j] < free_size[pick]) begin
					pick = j;
				end else if (mode_reg == MODE_WORST && free_size[j] > free_size[pick]) begin
					pick = j;
				end
			end
		end
		pl.granted = found;
		pl.block = found ? INDEX_W'(pick) : '0;
		return pl;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			mode_reg = MODE_FIRST;
			count_reg = '0;
			placement_q.delete();
		end else begin
			// compare each result transfer against the oldest prediction
			if (done) begin
				result_tally++;
				if (granted) grant_tally++;
				if (placement_q.size() == 0) begin
					$display("%0t: result with nothing outstanding: expected none, actual granted %0d block %0d",
						$time, granted, chosen_block);
					fail_tally++;
				end else begin
					want = placement_q.pop_front();
					if (granted !== want.granted) begin
						$display("%0t: granted mismatch: expected %0d actual %0d",
							$time, want.granted, granted);
						fail_tally++;
					end
					if (chosen_block !== want.block) begin
						$display("%0t: chosen_block mismatch: expected %0d actual %0d",
							$time, want.block, chosen_block);
						fail_tally++;
					end
				end
			end

			// track register writes
			if (cfg_wr_en) begin
				if (cfg_index == REG_FIT_MODE)
					mode_reg = cfg_wdata[MODE_W-1:0];
				else
					count_reg = cfg_wdata;
			end

			// apply each accepted item to the size table
			if (start && !busy) begin
				if (command == CMD_LOAD) begin
					free_size[block_index] = size_value;
				end else begin
					want = place_request(size_value);
					if (want.granted) free_size[want.block] = free_size[want.block] - size_value;
					placement_q.push_back(want);
				end
			end
		end
		fail_count <= fail_tally;
		pending <= placement_q.size();
		result_count <= result_tally;
		grant_count <= grant_tally;
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import fpba_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 24;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic                 cfg_index;
	logic [COUNT_W-1:0]   cfg_wdata;
	logic                 start;
	logic                 busy;
	logic                 command;
	logic [INDEX_W-1:0]   block_index;
	logic [VALUE_W-1:0]   size_value;
	logic                 done;
	logic                 granted;
	logic [INDEX_W-1:0]   chosen_block;

	int                   fail_count;
	int                   pending;
	int                   result_count;
	int                   grant_count;
	int                   cycle_count = 0;
	int                   transfer_count = 0;
	int                   request_count = 0;
	int                   setting_count = 0;
	int                   idle_pct = 0;

	fit_policy_block_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.block_index  (block_index),
		.size_value   (size_value),
		.done         (done),
		.granted      (granted),
		.chosen_block (chosen_block)
	);

	fpba_checker placement_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.block_index  (block_index),
		.size_value   (size_value),
		.done         (done),
		.granted      (granted),
		.chosen_block (chosen_block),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.grant_count  (grant_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fit_policy_block_allocator_unit verification failed");
			$finish;
		end
	end

	// Present one item and hold it until the transfer
	task automatic drive_item(input logic cmd, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] sz);
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		block_index <= idx;
		size_value <= sz;
		do @(posedge clk); while (busy);
		transfer_count++;
		if (cmd == CMD_ALLOC) request_count++;
	endtask

	// Drop start between items, at the current idle rate
	task automatic pace();
		int gap;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Hold off until every predicted result has arrived and the unit is idle
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	// Write both registers while nothing is in flight
	task automatic set_config(input logic [COUNT_W-1:0] mode_word,
			input logic [COUNT_W-1:0] count_word);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FIT_MODE;
		cfg_wdata <= mode_word;
		@(negedge clk);
		cfg_index <= REG_BLOCK_COUNT;
		cfg_wdata <= count_word;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		setting_count++;
	endtask

	// One random item: mostly requests against a table that gets refilled often
	task automatic random_item();
		logic [VALUE_W-1:0] sz;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			sz = ($urandom_range(0, 2) == 0) ? VALUE_W'($urandom) : VALUE_W'($urandom_range(0, 2000));
			drive_item(CMD_LOAD, INDEX_W'($urandom), sz);
		end else begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				sz = '0;
			else if (pick == 1)
				sz = VALUE_W'($urandom);
			else
				sz = VALUE_W'($urandom_range(1, 600));
			drive_item(CMD_ALLOC, INDEX_W'($urandom), sz);
		end
	endtask

	initial begin
		logic [VALUE_W-1:0] seed_sizes [16];
		logic [COUNT_W-1:0] phase_count [8];
		int phase_idle [8];
		int phase_items;

		seed_sizes = '{16'd100, 16'hFFFF, 16'd50, 16'd100, 16'd0, 16'd300, 16'd50, 16'h8000,
			16'd7, 16'd300, 16'd1, 16'h7FFF, 16'd200, 16'd50, 16'h1234, 16'hFFFF};
		phase_count = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'($urandom_range(2, 15)),
			5'd16, 5'($urandom_range(2, 15))};
		phase_idle = '{0, 78, 9, 0, 78, 9, 78, 0};

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_FIT_MODE;
		cfg_wdata = '0;
		start = 1'b0;
		command = CMD_LOAD;
		block_index = '0;
		size_value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// count zero after reset: refuse without touching the table
		drive_item(CMD_ALLOC, 4'd0, 16'd5);

		// fill every block, with ties and both size extremes
		for (int i = 0; i < 16; i++) drive_item(CMD_LOAD, INDEX_W'(i), seed_sizes[i]);

		// first fit: zero request, then a request only the largest blocks meet
		set_config(COUNT_W'(MODE_FIRST), 5'd16);
		drive_item(CMD_ALLOC, 4'd9, 16'd0);
		drive_item(CMD_ALLOC, 4'd0, 16'hFFFF);

		// best fit picks the lowest of the tied smallest blocks
		set_config(COUNT_W'(MODE_BEST), 5'd16);
		drive_item(CMD_ALLOC, 4'd15, 16'd50);

		// worst fit
		set_config(COUNT_W'(MODE_WORST), 5'd16);
		drive_item(CMD_ALLOC, 4'd3, 16'd10);

		// spare mode code, with the unused data bits set
		set_config(5'h1F, 5'd16);
		drive_item(CMD_ALLOC, 4'd0, 16'd1);

		// oversized count saturates
		set_config(COUNT_W'(MODE_BEST), 5'd17);
		drive_item(CMD_ALLOC, 4'd0, 16'h9000);

		// single block searched
		set_config(COUNT_W'(MODE_FIRST), 5'd1);
		drive_item(CMD_ALLOC, 4'd0, 16'd200);
		drive_item(CMD_ALLOC, 4'd0, 16'd99);

		// random phases across modes, counts and idle rates
		for (int ph = 0; ph < 8; ph++) begin
			idle_pct = 0;
			set_config(COUNT_W'(ph % 4) | COUNT_W'($urandom_range(0, 7) << 2), phase_count[ph]);
			idle_pct = phase_idle[ph];
			phase_items = (phase_count[ph] == 0) ? 60 : 235;
			for (int n = 0; n < phase_items; n++) begin
				pace();
				// now and then let everything drain before going on
				if ($urandom_range(0, 99) < 2) drain();
				random_item();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d transfers, %0d of them requests, over %0d register settings",
			transfer_count, request_count, setting_count);
		$display("compared %0d results: %0d granted, %0d refused",
			result_count, grant_count, result_count - grant_count);
		if (fail_count == 0 && pending == 0) begin
			$display("fit_policy_block_allocator_unit verification clean");
		end else begin
			$display("fit_policy_block_allocator_unit verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fpba_ctrl.sv
rtl/fpba_dpath.sv
rtl/fit_policy_block_allocator_unit.sv
verif/fpba_checker.sv
verif/testbench.sv
